/* design/sfr_pkg.sv */
// shared constants, types and helpers for the serial frame receiver
`default_nettype none

package sfr_pkg;

  // payload length of one frame
  localparam int PAYLOAD_BYTES = 8;

  // frame header bytes
  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'hCC;

  // widths derived from the payload length
  localparam int IDX_W   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CNT_W   = $clog2(PAYLOAD_BYTES + 1);
  localparam int RAM_DEPTH = 2 * PAYLOAD_BYTES;
  localparam int ADDR_W  = $clog2(RAM_DEPTH);
  localparam int BIDX_W  = 5;

  // frame handed from the parser to the burst side
  typedef struct packed {
    logic valid;
    logic bank;
  } sfr_frame_t;

  // payload buffer address of one byte in one bank
  function automatic logic [ADDR_W-1:0] sfr_addr(input logic bank,
                                                 input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = bank ? ADDR_W'(PAYLOAD_BYTES) : '0;
    return base + ADDR_W'(idx);
  endfunction

endpackage

`default_nettype wire

/* design/sfr_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/sfr_front.sv */
// frame parser: header hunt, payload capture, checksum check
`default_nettype none

module sfr_front
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              line_error,
  input  wire logic              consumer_busy,
  input  wire logic              done,
  output sfr_frame_t             frame,
  output logic                   we,
  output logic      [ADDR_W-1:0] waddr,
  output logic      [7:0]        wdata
);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]       checksum, checksum_next;
  logic             wbank, wbank_next;
  logic [1:0]       pending, pending_next;
  logic             acc;
  logic [IDX_W-1:0] pos;

  // both banks owned by the burst side: hold off new bytes
  assign in_stall = (pending == 2'd2);
  assign acc      = in_valid && !in_stall;
  assign pos      = IDX_W'(CNT_W'(PAYLOAD_BYTES) - bytes_left);
  assign waddr    = sfr_addr(wbank, pos);
  assign wdata    = rx_byte;

  // parse one request
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    checksum_next   = checksum;
    wbank_next      = wbank;
    we              = 1'b0;
    frame.valid     = 1'b0;
    frame.bank      = wbank;
    if (acc && !line_error) begin
      case (phase)
        PH_SECOND: begin
          if (rx_byte == HDR_SECOND) begin
            bytes_left_next = CNT_W'(PAYLOAD_BYTES);
            checksum_next   = checksum ^ HDR_SECOND;
            phase_next      = PH_BODY;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (bytes_left != '0) begin
            we              = 1'b1;
            checksum_next   = checksum ^ rx_byte;
            bytes_left_next = bytes_left - CNT_W'(1);
          end else begin
            if (rx_byte == checksum && !consumer_busy) begin
              frame.valid = 1'b1;
              wbank_next  = ~wbank;
            end
            phase_next = PH_HUNT;
          end
        end
        default: begin
          if (rx_byte == HDR_FIRST) begin
            checksum_next = HDR_FIRST;
            phase_next    = PH_SECOND;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  // count of frames handed off and not yet fully read back
  always_comb begin
    case ({frame.valid, done})
      2'b10:   pending_next = pending + 2'd1;
      2'b01:   pending_next = pending - 2'd1;
      default: pending_next = pending;
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      bytes_left <= '0;
      checksum   <= '0;
      wbank      <= 1'b0;
      pending    <= 2'd0;
    end else begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      checksum   <= checksum_next;
      wbank      <= wbank_next;
      pending    <= pending_next;
    end
  end

`ifndef SYNTHESIS
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("frame count out of range");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> (pending != 2'd2))
    else $error("frame handed off with both banks owned");
  a_write_in_body: assert property (@(posedge clk) disable iff (rst)
    we |=> (bytes_left == $past(bytes_left) - CNT_W'(1)) && (wbank == $past(wbank)))
    else $error("payload write did not advance the capture count");
`endif

endmodule

`default_nettype wire

/* design/sfr_fifo.sv */
// two-entry queue of captured frame banks
`default_nettype none

module sfr_fifo
  import sfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire sfr_frame_t push,
  input  wire logic       pop,
  output logic            valid,
  output logic            bank
);

  logic [1:0] entry;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign valid = (count != 2'd0);
  assign bank  = entry[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry[wptr] <= push.bank;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push.valid) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/sfr_back.sv */
// burst side: reads a captured frame back and drives the output register
`default_nettype none

module sfr_back
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fifo_valid,
  input  wire logic              fifo_bank,
  output logic                   pop,
  output logic                   re,
  output logic      [ADDR_W-1:0] raddr,
  input  wire logic [7:0]        rdata,
  output logic                   done,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [7:0]        payload_byte,
  output logic      [BIDX_W-1:0] byte_index,
  output logic                   last_byte
);

  logic             active;
  logic             bank;
  logic             inflight;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] rd_idx;
  logic             load;
  logic             rd_last;

  // output register free this cycle and read data waiting
  assign load    = inflight && (!out_valid || !out_stall);
  assign rd_last = (rd_idx == CNT_W'(PAYLOAD_BYTES - 1));
  assign pop     = !active && fifo_valid;
  assign re      = active && (rd_cnt != CNT_W'(PAYLOAD_BYTES)) && (!inflight || load);
  assign raddr   = sfr_addr(bank, IDX_W'(rd_cnt));
  assign done    = load && rd_last;

  // burst control
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      inflight <= 1'b0;
      rd_cnt   <= '0;
    end else begin
      if (pop) begin
        active <= 1'b1;
        rd_cnt <= '0;
      end else if (done) begin
        active <= 1'b0;
      end
      if (re) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      inflight <= re || (inflight && !load);
    end
  end

  // frame bank and index of the byte in the read register
  always_ff @(posedge clk) begin
    if (pop) begin
      bank <= fifo_bank;
    end
    if (re) begin
      rd_idx <= rd_cnt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      payload_byte <= rdata;
      byte_index   <= BIDX_W'(rd_idx);
      last_byte    <= rd_last;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    !active |-> !inflight)
    else $error("read in flight outside a burst");
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |-> inflight)
    else $error("burst stalled without the next byte in flight");
  a_done_shows_last: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid && last_byte)
    else $error("burst ended without a last byte at the output");
`endif

endmodule

`default_nettype wire

/* design/serial_frame_receiver.sv */
// Serial frame receiver, top level.
// Input channel (in_valid / in_stall): one received byte per request with its
// line-error flag and the consumer busy flag. Bytes with a line error are
// dropped. A frame is 0xAA, 0xCC, PAYLOAD_BYTES payload bytes and an XOR
// checksum byte seeded with 0xAA; a good frame with the consumer not busy
// comes out as a burst of PAYLOAD_BYTES requests on the output channel
// (out_valid / out_stall), with byte_index counting from 0 and last_byte on
// the final one. Bad or unwanted frames vanish without output.
// The parser takes one byte per cycle while in_stall is low. Captured payloads
// sit in a two-bank buffer; a two-entry queue hands banks to the burst side,
// which reads one byte per cycle from the buffer memory and emits one result
// per cycle while out_stall is low. With the burst side idle, the first result
// of a frame passes the queue count, active flag, read data and output register.
// in_stall rises while two finished frames still wait to be read out, and
// falls as soon as the oldest burst has left the buffer.
// A stalled output holds its byte; the burst side then waits and the parser
// keeps running until both banks are full.
// Synchronous reset returns the parser to header hunt and empties the queue
// and output register; buffer contents need no clearing.
`default_nettype none

module serial_frame_receiver
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              line_error,
  input  wire logic              consumer_busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [7:0]        payload_byte,
  output logic      [BIDX_W-1:0] byte_index,
  output logic                   last_byte
);

  sfr_frame_t        frame;
  logic              done;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic              fifo_valid;
  logic              fifo_bank;
  logic              pop;

  // parser
  sfr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .line_error    (line_error),
    .consumer_busy (consumer_busy),
    .done          (done),
    .frame         (frame),
    .we            (we),
    .waddr         (waddr),
    .wdata         (wdata)
  );

  // two-bank payload buffer
  sfr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // frame queue
  sfr_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (frame),
    .pop   (pop),
    .valid (fifo_valid),
    .bank  (fifo_bank)
  );

  // burst output
  sfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_valid   (fifo_valid),
    .fifo_bank    (fifo_bank),
    .pop          (pop),
    .re           (re),
    .raddr        (raddr),
    .rdata        (rdata),
    .done         (done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last_byte    (last_byte)
  );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for the serial frame receiver
`default_nettype none

module tb_top
  import sfr_pkg::*;
();

  typedef enum logic [1:0] {
    HUNT,
    WANT_CC,
    BODY
  } parse_phase_t;

  typedef struct {
    logic [7:0]        data;
    logic [BIDX_W-1:0] idx;
    logic              last;
  } payload_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = 8'h00;
  logic              line_error = 1'b0;
  logic              consumer_busy = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        payload_byte;
  logic [BIDX_W-1:0] byte_index;
  logic              last_byte;

  // predictor state
  parse_phase_t  phase = HUNT;
  logic [5:0]    left_cnt = '0;
  logic [7:0]    run_sum = '0;
  logic [7:0]    held_payload [PAYLOAD_BYTES];
  payload_beat_t burst_q [$];

  // stimulus and idling control
  logic [7:0] frame_pl [PAYLOAD_BYTES];
  bit         in_idle_on = 1'b1;
  bit         out_idle_on = 1'b1;
  int         stall_left = 0;
  int         hold_req = 0;
  int         clean_sent = 0;
  int         errors = 0;

  serial_frame_receiver uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .line_error   (line_error),
    .consumer_busy(consumer_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last_byte    (last_byte)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // parser prediction: one accepted byte in, pushes the burst it releases
  task automatic frame_parse(input logic [7:0] b, input logic err, input logic busy);
    payload_beat_t beat;
    int k;
    if (!err) begin
      case (phase)
        WANT_CC: begin
          if (b == HDR_SECOND) begin
            left_cnt = 6'(PAYLOAD_BYTES);
            run_sum  = run_sum ^ HDR_SECOND;
            phase    = BODY;
          end else begin
            phase = HUNT;
          end
        end
        BODY: begin
          if (left_cnt != 0) begin
            held_payload[PAYLOAD_BYTES - int'(left_cnt)] = b;
            run_sum  = run_sum ^ b;
            left_cnt = left_cnt - 6'd1;
          end else begin
            if (b == run_sum && !busy) begin
              for (k = 0; k < PAYLOAD_BYTES; k++) begin
                beat.data = held_payload[k];
                beat.idx  = BIDX_W'(k);
                beat.last = (k == PAYLOAD_BYTES - 1);
                burst_q.push_back(beat);
              end
            end
            phase = HUNT;
          end
        end
        default: begin
          if (b == HDR_FIRST) begin
            run_sum = HDR_FIRST;
            phase   = WANT_CC;
          end else begin
            phase = HUNT;
          end
        end
      endcase
    end
  endtask

  // offer one byte request and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic err, input logic busy);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    rx_byte       <= b;
    line_error    <= err;
    consumer_busy <= busy;
    do @(posedge clk); while (in_stall);
    frame_parse(b, err, busy);
    if (!err) clean_sent++;
  endtask

  // clean byte, sometimes preceded by a corrupted one
  task automatic send_noisy(input logic [7:0] b, input logic busy, input int err_pct);
    if ($urandom_range(0, 99) < err_pct)
      send_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
    send_byte(b, 1'b0, busy);
  endtask

  // whole frame from frame_pl with a good or corrupted checksum
  task automatic send_frame(input bit sum_ok, input logic busy, input int err_pct);
    logic [7:0] sum;
    int k;
    sum = HDR_FIRST ^ HDR_SECOND;
    for (k = 0; k < PAYLOAD_BYTES; k++) sum = sum ^ frame_pl[k];
    if (!sum_ok) sum = sum ^ 8'($urandom_range(1, 255));
    send_noisy(HDR_FIRST, 1'($urandom_range(0, 1)), err_pct);
    send_noisy(HDR_SECOND, 1'($urandom_range(0, 1)), err_pct);
    for (k = 0; k < PAYLOAD_BYTES; k++)
      send_noisy(frame_pl[k], 1'($urandom_range(0, 1)), err_pct);
    send_noisy(sum, busy, err_pct);
  endtask

  // sender stays quiet until every predicted byte has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (burst_q.size() != 0) @(posedge clk);
  endtask

  task automatic fill_payload(input bit extremes);
    int k;
    for (k = 0; k < PAYLOAD_BYTES; k++) begin
      case (extremes ? $urandom_range(0, 3) : 3)
        0:       frame_pl[k] = 8'h00;
        1:       frame_pl[k] = 8'hFF;
        default: frame_pl[k] = 8'($urandom_range(0, 255));
      endcase
    end
  endtask

  // good frame with extreme payload bytes and corrupted bytes mixed in
  task automatic test_line_errors();
    frame_pl = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hCC, 8'h01, 8'h80, 8'h7F};
    send_byte(HDR_FIRST, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_frame(1'b1, 1'b0, 25);
    wait_drained();
  endtask

  // second header byte wrong, including a repeated first header byte
  task automatic test_wrong_second();
    send_byte(HDR_FIRST, 1'b0, 1'b0);
    send_byte(HDR_FIRST, 1'b0, 1'b0);
    send_byte(HDR_SECOND, 1'b0, 1'b0);
    send_byte(HDR_FIRST, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_bad_checksum();
    fill_payload(1'b1);
    send_frame(1'b0, 1'b0, 0);
    wait_drained();
  endtask

  task automatic test_consumer_busy();
    fill_payload(1'b1);
    send_frame(1'b1, 1'b1, 0);
    wait_drained();
  endtask

  // mostly well-formed frames, with noise and broken headers between them
  task automatic test_random_frames(input int n_items);
    int target;
    int n;
    target = clean_sent + n_items;
    while (clean_sent < target) begin
      in_idle_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        7: begin
          for (n = $urandom_range(1, 6); n > 0; n--)
            send_noisy($urandom_range(0, 3) == 0 ? HDR_FIRST : 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 10);
        end
        8: begin
          send_noisy(HDR_FIRST, 1'b0, 10);
          send_noisy(HDR_SECOND, 1'b0, 10);
          for (n = $urandom_range(0, PAYLOAD_BYTES - 1); n > 0; n--)
            send_noisy(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 10);
        end
        9: begin
          send_noisy(HDR_FIRST, 1'b0, 10);
          send_noisy(8'($urandom_range(0, 255)), 1'b0, 10);
        end
        default: begin
          fill_payload($urandom_range(0, 3) == 0);
          send_frame($urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0, 8);
        end
      endcase
    end
    in_idle_on = 1'b1;
    wait_drained();
  endtask

  // receiver holds off while frames keep coming, so the input must stall
  task automatic test_backpressure();
    int k;
    in_idle_on = 1'b0;
    hold_req = 400;
    for (k = 0; k < 5; k++) begin
      fill_payload(1'b0);
      send_frame(1'b1, 1'b0, 0);
    end
    in_idle_on = 1'b1;
    wait_drained();
  endtask

  // receiver stall, one countdown per result
  always @(negedge clk) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // compare every taken result with the oldest prediction
  always @(posedge clk) begin : check_beat
    payload_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (burst_q.size() == 0) begin
        report("unexpected payload byte", payload_byte, 0);
      end else begin
        want = burst_q.pop_front();
        if (payload_byte !== want.data) report("payload_byte", payload_byte, want.data);
        if (byte_index !== want.idx) report("byte_index", byte_index, want.idx);
        if (last_byte !== want.last) report("last_byte", last_byte, want.last);
      end
      stall_left = out_idle_on ? $urandom_range(0, 19) : 0;
      if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_line_errors();
    test_wrong_second();
    test_bad_checksum();
    test_consumer_busy();
    test_random_frames(360);
    test_backpressure();
    while (burst_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
